[hdl/lcec_pkg.sv]
`default_nettype none
package lcec_pkg;

   // top pixel kinds
   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_SEMI   = 2'd1;
   localparam logic [1:0] KIND_BITMAP = 2'd2;
   localparam logic [1:0] KIND_3D     = 2'd3;

   // effect selection in effect_control bits 6-7
   localparam logic [1:0] EFFECT_NONE     = 2'd0;
   localparam logic [1:0] EFFECT_BLEND    = 2'd1;
   localparam logic [1:0] EFFECT_BRIGHTEN = 2'd2;
   localparam logic [1:0] EFFECT_DARKEN   = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_EFFECT_CONTROL      = 2'd0;
   localparam logic [1:0] CSR_BLEND_WEIGHT_TOP    = 2'd1;
   localparam logic [1:0] CSR_BLEND_WEIGHT_SECOND = 2'd2;
   localparam logic [1:0] CSR_FADE_WEIGHT         = 2'd3;

   // what to do with the shifted sum in the last stage
   localparam logic [1:0] POST_SAT = 2'd0;
   localparam logic [1:0] POST_ADD = 2'd1;
   localparam logic [1:0] POST_SUB = 2'd2;

   localparam logic [5:0] CHAN_MAX    = 6'h3F;
   localparam logic [4:0] WEIGHT_FULL = 5'd16;
   localparam logic [5:0] WEIGHT_3D   = 6'd32;
   localparam logic [4:0] ALPHA_3D_OPAQUE = 5'h1F;
   localparam logic [4:0] BIAS_ROUND  = 5'd8;
   localparam logic [4:0] BIAS_DARKEN = 5'd7;
   localparam logic [4:0] BIAS_3D     = 5'd16;

   typedef logic [5:0] chan_type;

   typedef struct packed {
      logic [15:0] effect_control;
      logic [4:0]  blend_weight_top;
      logic [4:0]  blend_weight_second;
      logic [4:0]  fade_weight;
   } cfg_type;

   typedef struct packed {
      logic [31:0] top_colour;
      logic [23:0] second_colour;
      logic [5:0]  top_layer_bit;
      logic [5:0]  second_layer_bit;
      logic [1:0]  top_class;
      logic [4:0]  sprite_alpha;
      logic        effects_enabled;
   } pixel_type;

   typedef struct packed {
      chan_type a;
      chan_type b;
      chan_type c;
   } lane_op_type;

   typedef struct packed {
      lane_op_type [2:0] lane;
      chan_type          wa;
      chan_type          wb;
      logic [4:0]        bias;
      logic              shift5;
      logic [1:0]        post;
      logic              pass;
      logic [23:0]       colour;
   } dec_type;

   typedef struct packed {
      logic [11:0] pa;
      logic [11:0] pb;
      chan_type    c;
   } lane_prod_type;

   typedef struct packed {
      lane_prod_type [2:0] lane;
      logic [4:0]          bias;
      logic                shift5;
      logic [1:0]          post;
      logic                pass;
      logic [23:0]         colour;
   } prod_type;

endpackage
`default_nettype wire

[hdl/lcec_if.sv]
`default_nettype none
interface lcec_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] top_colour;
   logic [23:0] second_colour;
   logic [5:0]  top_layer_bit;
   logic [5:0]  second_layer_bit;
   logic [1:0]  top_class;
   logic [4:0]  sprite_alpha;
   logic        effects_enabled;

   modport source (
      output valid, top_colour, second_colour, top_layer_bit, second_layer_bit,
             top_class, sprite_alpha, effects_enabled,
      input  ready
   );
   modport sink (
      input  valid, top_colour, second_colour, top_layer_bit, second_layer_bit,
             top_class, sprite_alpha, effects_enabled,
      output ready
   );
endinterface

interface lcec_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] result_colour;

   modport source (output valid, result_colour, input ready);
   modport sink (input valid, result_colour, output ready);
endinterface
`default_nettype wire

[hdl/layer_colour_effect_compositor.sv]
`default_nettype none
// Channel   Kind            Direction  Contents
// req_bus   valid/ready     in         top and second colours, layer bits, kind, alpha, window
// rsp_bus   valid/ready     out        result_colour, 6-bit R/G/B in a 24-bit word
// csr_*     write only      in         effect control, two blend weights, fade weight
//
// Three register stages: decode, multiply, resolve. One pixel a cycle sustained while
// rsp_bus is ready; each accepted req beat passes through all three register stages
// on its way to its rsp beat, and the ready chain lets every stage advance together.
// Reset clears the valid bits and all four registers to zero.
// Each stage holds its beat while the one after it is full and stalled, so a bubble
// anywhere lets req_bus take another pixel while a finished rsp beat waits.
module layer_colour_effect_compositor (
   input  wire logic        clock,
   input  wire logic        reset,
   lcec_req_if.sink         req_bus,
   lcec_rsp_if.source       rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import lcec_pkg::*;

   cfg_type   cfg_ff;
   pixel_type pixel;
   logic      dec_valid;
   logic      dec_ready;
   dec_type   dec_data;
   logic      mul_valid;
   logic      mul_ready;
   prod_type  mul_data;

   // register file: the user must write it only while the pipeline is empty; not enforced here
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EFFECT_CONTROL:      cfg_ff.effect_control      <= csr_write_data;
            CSR_BLEND_WEIGHT_TOP:    cfg_ff.blend_weight_top    <= csr_write_data[4:0];
            CSR_BLEND_WEIGHT_SECOND: cfg_ff.blend_weight_second <= csr_write_data[4:0];
            CSR_FADE_WEIGHT:         cfg_ff.fade_weight         <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   // gather the req beat into one word
   assign pixel.top_colour       = req_bus.top_colour;
   assign pixel.second_colour    = req_bus.second_colour;
   assign pixel.top_layer_bit    = req_bus.top_layer_bit;
   assign pixel.second_layer_bit = req_bus.second_layer_bit;
   assign pixel.top_class        = req_bus.top_class;
   assign pixel.sprite_alpha     = req_bus.sprite_alpha;
   assign pixel.effects_enabled  = req_bus.effects_enabled;

   // decide the path and pick operands, weights and rounding bias
   lcec_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (pixel),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // form both weighted products for each channel
   lcec_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   // round, shift, add or subtract, saturate and drop in the passthrough colour where needed
   lcec_resolve u_resolve (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mul_valid),
      .in_ready   (mul_ready),
      .in_data    (mul_data),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_colour (rsp_bus.result_colour)
   );
endmodule
`default_nettype wire

[hdl/lcec_decode.sv]
`default_nettype none
module lcec_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lcec_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire lcec_pkg::pixel_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output lcec_pkg::dec_type        out_data
);
   import lcec_pkg::*;

   logic     valid_ff;
   dec_type  data_ff;
   dec_type  data_in;
   logic     second_target;
   logic     first_target;
   logic     brighten;
   logic [4:0] fade_clamped;
   logic [4:0] sprite_clamped;
   logic [4:0] alpha_3d;
   chan_type   weight_3d;
   chan_type   top_chan;
   chan_type   sec_chan;

   assign second_target = |(cfg.effect_control[13:8] & in_data.second_layer_bit);
   assign first_target  = |(cfg.effect_control[5:0] & in_data.top_layer_bit);
   assign fade_clamped   = (cfg.fade_weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg.fade_weight;
   assign sprite_clamped = (in_data.sprite_alpha > WEIGHT_FULL) ? WEIGHT_FULL
                                                                : in_data.sprite_alpha;
   assign alpha_3d  = in_data.top_colour[28:24];
   assign weight_3d = {1'b0, alpha_3d} + 6'd1;

   always_comb begin
      data_in        = '0;
      data_in.pass   = 1'b1;
      data_in.bias   = BIAS_ROUND;
      data_in.post   = POST_SAT;
      data_in.colour = in_data.top_colour[23:0];
      brighten       = 1'b0;
      if (((in_data.top_class == KIND_SEMI) || (in_data.top_class == KIND_BITMAP))
          && second_target) begin
         data_in.pass = 1'b0;
         if (in_data.top_class == KIND_BITMAP) begin
            data_in.wa = {1'b0, sprite_clamped};
            data_in.wb = {1'b0, WEIGHT_FULL - sprite_clamped};
         end else begin
            data_in.wa = {1'b0, cfg.blend_weight_top};
            data_in.wb = {1'b0, cfg.blend_weight_second};
         end
      end else if ((in_data.top_class == KIND_3D) && second_target) begin
         // an opaque 3D pixel passes straight through
         if (alpha_3d != ALPHA_3D_OPAQUE) begin
            data_in.pass   = 1'b0;
            data_in.wa     = weight_3d;
            data_in.wb     = WEIGHT_3D - weight_3d;
            data_in.bias   = BIAS_3D;
            data_in.shift5 = 1'b1;
         end
      end else if (first_target && in_data.effects_enabled) begin
         case (cfg.effect_control[7:6])
            EFFECT_BLEND: begin
               if (second_target) begin
                  data_in.pass = 1'b0;
                  data_in.wa   = {1'b0, cfg.blend_weight_top};
                  data_in.wb   = {1'b0, cfg.blend_weight_second};
               end
            end
            EFFECT_BRIGHTEN: begin
               data_in.pass = 1'b0;
               data_in.wa   = {1'b0, fade_clamped};
               data_in.post = POST_ADD;
               brighten     = 1'b1;
            end
            EFFECT_DARKEN: begin
               data_in.pass = 1'b0;
               data_in.wa   = {1'b0, fade_clamped};
               data_in.bias = BIAS_DARKEN;
               data_in.post = POST_SUB;
            end
            default: begin
            end
         endcase
      end
      for (int k = 0; k < 3; k++) begin
         top_chan = in_data.top_colour[8*k +: 6];
         sec_chan = in_data.second_colour[8*k +: 6];
         data_in.lane[k].a = brighten ? (CHAN_MAX - top_chan) : top_chan;
         data_in.lane[k].b = sec_chan;
         data_in.lane[k].c = top_chan;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end
endmodule
`default_nettype wire

[hdl/lcec_mul.sv]
`default_nettype none
module lcec_mul (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire lcec_pkg::dec_type  in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output lcec_pkg::prod_type     out_data
);
   import lcec_pkg::*;

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;

   always_comb begin
      data_in.bias   = in_data.bias;
      data_in.shift5 = in_data.shift5;
      data_in.post   = in_data.post;
      data_in.pass   = in_data.pass;
      data_in.colour = in_data.colour;
      for (int k = 0; k < 3; k++) begin
         data_in.lane[k].pa = {6'd0, in_data.lane[k].a} * {6'd0, in_data.wa};
         data_in.lane[k].pb = {6'd0, in_data.lane[k].b} * {6'd0, in_data.wb};
         data_in.lane[k].c  = in_data.lane[k].c;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end
endmodule
`default_nettype wire

[hdl/lcec_resolve.sv]
`default_nettype none
module lcec_resolve (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire lcec_pkg::prod_type  in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [23:0]            out_colour
);
   import lcec_pkg::*;

   logic        valid_ff;
   logic [23:0] colour_ff;
   logic [23:0] colour_in;
   logic [12:0] sum;
   logic [8:0]  scaled;
   logic [9:0]  raised;
   chan_type    lane_out;

   always_comb begin
      colour_in = '0;
      for (int k = 0; k < 3; k++) begin
         sum = {1'b0, in_data.lane[k].pa} + {1'b0, in_data.lane[k].pb}
               + {8'd0, in_data.bias};
         scaled = in_data.shift5 ? {1'b0, sum[12:5]} : sum[12:4];
         raised = {1'b0, scaled} + {4'd0, in_data.lane[k].c};
         case (in_data.post)
            POST_ADD: lane_out = (raised > {4'd0, CHAN_MAX}) ? CHAN_MAX : raised[5:0];
            POST_SUB: lane_out = (scaled > {3'd0, in_data.lane[k].c}) ? 6'd0
                                 : in_data.lane[k].c - scaled[5:0];
            default:  lane_out = (scaled > {3'd0, CHAN_MAX}) ? CHAN_MAX : scaled[5:0];
         endcase
         colour_in[8*k +: 8] = {2'b00, lane_out};
      end
      if (in_data.pass) begin
         colour_in = in_data.colour;
      end
   end

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_colour = colour_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         colour_ff <= colour_in;
      end
   end
endmodule
`default_nettype wire

[dv/colour_result_checker.sv]
`default_nettype none
module colour_result_checker
   import lcec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   lcec_req_if              req_mon,
   lcec_rsp_if              rsp_mon,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   output int               mismatch_count,
   output int               pixels_outstanding
);

   cfg_type     setting = '0;
   pixel_type   seen_pixel;
   logic [23:0] expected_colours[$];
   int          errors_seen = 0;
   int          colours_waiting = 0;

   assign mismatch_count     = errors_seen;
   assign pixels_outstanding = colours_waiting;

   assign seen_pixel = {req_mon.top_colour, req_mon.second_colour, req_mon.top_layer_bit,
                        req_mon.second_layer_bit, req_mon.top_class, req_mon.sprite_alpha,
                        req_mon.effects_enabled};

   task automatic report_mismatch(input string detail);
      $display("%0t: mismatch: %s", $realtime, detail);
      errors_seen++;
   endtask

   // weighted mix in sixteenths, each channel saturating at full scale
   function automatic logic [23:0] blend16(input logic [31:0] a, input logic [23:0] b,
                                           input int unsigned wa, input int unsigned wb);
      logic [23:0] o;
      int unsigned ca, cb, v;
      o = '0;
      for (int k = 0; k < 3; k++) begin
         ca = 32'(a[8*k +: 6]);
         cb = 32'(b[8*k +: 6]);
         v  = (ca * wa + cb * wb + 32'(BIAS_ROUND)) >> 4;
         o[8*k +: 6] = (v > 32'(CHAN_MAX)) ? CHAN_MAX : v[5:0];
      end
      return o;
   endfunction

   // 3D mix in 32 steps; an opaque pixel passes through untouched
   function automatic logic [23:0] blend3d(input logic [31:0] a, input logic [23:0] b);
      logic [23:0] o;
      int unsigned wa, wb, ca, cb, v;
      wa = 32'(a[28:24]) + 32'd1;
      wb = 32'(WEIGHT_3D) - wa;
      if (wa == 32'(WEIGHT_3D)) return a[23:0];
      o = '0;
      for (int k = 0; k < 3; k++) begin
         ca = 32'(a[8*k +: 6]);
         cb = 32'(b[8*k +: 6]);
         v  = (ca * wa + cb * wb + 32'(BIAS_3D)) >> 5;
         o[8*k +: 6] = (v > 32'(CHAN_MAX)) ? CHAN_MAX : v[5:0];
      end
      return o;
   endfunction

   function automatic logic [23:0] brighten(input logic [31:0] a, input int unsigned f);
      logic [23:0] o;
      int unsigned c, v;
      o = '0;
      for (int k = 0; k < 3; k++) begin
         c = 32'(a[8*k +: 6]);
         v = c + (((32'(CHAN_MAX) - c) * f + 32'(BIAS_ROUND)) >> 4);
         o[8*k +: 6] = (v > 32'(CHAN_MAX)) ? CHAN_MAX : v[5:0];
      end
      return o;
   endfunction

   function automatic logic [23:0] darken(input logic [31:0] a, input int unsigned f);
      logic [23:0] o;
      int unsigned c, d;
      o = '0;
      for (int k = 0; k < 3; k++) begin
         c = 32'(a[8*k +: 6]);
         d = (c * f + 32'(BIAS_DARKEN)) >> 4;
         o[8*k +: 6] = (d > c) ? 6'd0 : 6'(c - d);
      end
      return o;
   endfunction

   function automatic logic [23:0] composite_colour(input pixel_type px, input cfg_type s);
      logic [1:0]  effect;
      logic        first_hit, second_hit;
      int unsigned fade, alpha;
      logic [23:0] o;
      effect     = s.effect_control[7:6];
      first_hit  = |(s.effect_control[5:0] & px.top_layer_bit);
      second_hit = |(s.effect_control[13:8] & px.second_layer_bit);
      fade       = 32'((s.fade_weight > WEIGHT_FULL) ? WEIGHT_FULL : s.fade_weight);
      alpha      = 32'((px.sprite_alpha > WEIGHT_FULL) ? WEIGHT_FULL : px.sprite_alpha);
      o          = px.top_colour[23:0];
      if ((px.top_class == KIND_SEMI || px.top_class == KIND_BITMAP) && second_hit) begin
         if (px.top_class == KIND_BITMAP)
            o = blend16(px.top_colour, px.second_colour, alpha,
                        32'(WEIGHT_FULL) - alpha);
         else
            o = blend16(px.top_colour, px.second_colour, 32'(s.blend_weight_top),
                        32'(s.blend_weight_second));
      end else if (px.top_class == KIND_3D && second_hit) begin
         o = blend3d(px.top_colour, px.second_colour);
      end else if (first_hit && px.effects_enabled) begin
         case (effect)
            EFFECT_BLEND: begin
               if (second_hit)
                  o = blend16(px.top_colour, px.second_colour, 32'(s.blend_weight_top),
                              32'(s.blend_weight_second));
            end
            EFFECT_BRIGHTEN: o = brighten(px.top_colour, fade);
            EFFECT_DARKEN:   o = darken(px.top_colour, fade);
            default: ;
         endcase
      end
      return o;
   endfunction

   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         expected_colours.delete();
         setting = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_colours.size() == 0) begin
               report_mismatch($sformatf("unexpected result_colour %06h",
                                         rsp_mon.result_colour));
            end else begin
               want = expected_colours.pop_front();
               if (rsp_mon.result_colour !== want)
                  report_mismatch($sformatf("result_colour %06h, expected %06h",
                                            rsp_mon.result_colour, want));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_colours.push_back(composite_colour(seen_pixel, setting));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_EFFECT_CONTROL:      setting.effect_control      = csr_write_data;
               CSR_BLEND_WEIGHT_TOP:    setting.blend_weight_top    = csr_write_data[4:0];
               CSR_BLEND_WEIGHT_SECOND: setting.blend_weight_second = csr_write_data[4:0];
               CSR_FADE_WEIGHT:         setting.fade_weight         = csr_write_data[4:0];
               default: ;
            endcase
         end
      end
      colours_waiting = expected_colours.size();
   end

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
module testbench;
   import lcec_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PHASES    = 8;
   localparam int PIXELS_PER_PHASE = 206;
   localparam int DIRECTED_PIXELS  = 6;
   localparam int SQUEEZE_PHASE    = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_EFFECT_CONTROL;
   logic [15:0] csr_write_data = '0;
   int          mismatch_count;
   int          pixels_outstanding;
   int          hold_off_asks = 0;
   int          cycle_count = 0;

   lcec_req_if req_bus();
   lcec_rsp_if rsp_bus();

   always #5 clock = ~clock;

   layer_colour_effect_compositor i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   colour_result_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_bus),
      .rsp_mon            (rsp_bus),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .pixels_outstanding (pixels_outstanding)
   );

   function automatic cfg_type make_setting(input logic [15:0] ec, input logic [4:0] wt,
                                            input logic [4:0] ws, input logic [4:0] wf);
      return {ec, wt, ws, wf};
   endfunction

   // Random register setting: weights mostly in range, now and then past sixteen
   // so that saturation and the fade clamp get exercised.
   function automatic cfg_type random_setting();
      cfg_type s;
      s.effect_control = 16'($urandom);
      // favour settings where targets actually match
      if ($urandom_range(0, 1) == 1) s.effect_control[13:8] = 6'h3F;
      if ($urandom_range(0, 1) == 1) s.effect_control[5:0]  = 6'h3F;
      s.blend_weight_top    = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 16));
      s.blend_weight_second = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 16));
      s.fade_weight         = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 16));
      return s;
   endfunction

   // Hand-picked pixels: extremes of every field, each pixel kind, the opaque
   // 3D pixel with stray bits between the channels, a blend with no second
   // target, an over-range sprite alpha and layer bits that are not one-hot.
   function automatic pixel_type directed_pixel(input int k);
      pixel_type px;
      case (k)
         0:       px = {32'hFFFF_FFFF, 24'hFF_FFFF, 6'h3F, 6'h3F, KIND_NORMAL, 5'h1F, 1'b1};
         1:       px = {32'h0000_0000, 24'h00_0000, 6'h01, 6'h00, KIND_NORMAL, 5'h00, 1'b1};
         2:       px = {32'h0015_3F00, 24'h3F_003F, 6'h10, 6'h01, KIND_SEMI,   5'h00, 1'b0};
         3:       px = {32'h003F_3F3F, 24'h00_0000, 6'h10, 6'h02, KIND_BITMAP, 5'h1F, 1'b1};
         4:       px = {32'hFFC0_2A15, 24'h3F_3F3F, 6'h01, 6'h04, KIND_3D,     5'h10, 1'b1};
         default: px = {32'h003F_3F3F, 24'h0A_0B0C, 6'h20, 6'h20, KIND_3D,     5'h08, 1'b1};
      endcase
      return px;
   endfunction

   function automatic logic [5:0] extreme_or(input logic [5:0] c);
      if ($urandom_range(0, 4) != 0) return c;
      return ($urandom_range(0, 1) == 1) ? CHAN_MAX : 6'd0;
   endfunction

   // Mostly tidy pixels (clean channels, one-hot layers, alpha in range) with
   // random content; one in ten is raw noise across every bit.
   function automatic pixel_type random_pixel();
      pixel_type px;
      px.top_colour       = $urandom;
      px.second_colour    = 24'($urandom);
      px.top_layer_bit    = 6'($urandom);
      px.second_layer_bit = 6'($urandom);
      px.top_class        = 2'($urandom);
      px.sprite_alpha     = 5'($urandom);
      px.effects_enabled  = 1'($urandom);
      if ($urandom_range(0, 9) != 0) begin
         for (int k = 0; k < 3; k++) begin
            px.top_colour[8*k +: 8]    = {2'b00, extreme_or(px.top_colour[8*k +: 6])};
            px.second_colour[8*k +: 8] = {2'b00, extreme_or(px.second_colour[8*k +: 6])};
         end
         px.top_colour[31:29] = 3'd0;
         if ($urandom_range(0, 7) == 0) px.top_colour[28:24] = ALPHA_3D_OPAQUE;
         px.top_layer_bit    = 6'd1 << $urandom_range(0, 5);
         px.second_layer_bit = 6'd1 << $urandom_range(0, 5);
         px.sprite_alpha     = 5'($urandom_range(0, 16));
         px.effects_enabled  = ($urandom_range(0, 3) != 0);
      end
      return px;
   endfunction

   // Offer one beat from the falling edge and hold it until it is taken.
   task automatic drive_pixel(input pixel_type px);
      @(negedge clock);
      req_bus.valid            <= 1'b1;
      req_bus.top_colour       <= px.top_colour;
      req_bus.second_colour    <= px.second_colour;
      req_bus.top_layer_bit    <= px.top_layer_bit;
      req_bus.second_layer_bit <= px.second_layer_bit;
      req_bus.top_class        <= px.top_class;
      req_bus.sprite_alpha     <= px.sprite_alpha;
      req_bus.effects_enabled  <= px.effects_enabled;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid for a gap whose length is set by n; n of zero keeps the stream going.
   task automatic pause_sender(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Wait until every predicted colour has come out, then let the pipeline idle for
   // SETTLE_CYCLES so nothing is in flight when the registers change.
   task automatic wait_drained();
      do @(negedge clock); while (pixels_outstanding != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all four registers back to back; weight writes carry junk in the
   // unused upper data bits, which the block must ignore.
   task automatic write_settings(input cfg_type s);
      logic [15:0] filler;
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_EFFECT_CONTROL;
      csr_write_data   <= s.effect_control;
      filler = 16'($urandom);
      @(negedge clock);
      csr_index        <= CSR_BLEND_WEIGHT_TOP;
      csr_write_data   <= {filler[15:5], s.blend_weight_top};
      filler = 16'($urandom);
      @(negedge clock);
      csr_index        <= CSR_BLEND_WEIGHT_SECOND;
      csr_write_data   <= {filler[15:5], s.blend_weight_second};
      filler = 16'($urandom);
      @(negedge clock);
      csr_index        <= CSR_FADE_WEIGHT;
      csr_write_data   <= {filler[15:5], s.fade_weight};
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One phase: settle, reprogram, then stream pixels in bursts with gaps.
   task automatic run_phase(input cfg_type s, input int n, input bit directed,
                            input bit squeeze);
      int        sent;
      int        burst;
      pixel_type px;
      wait_drained();
      write_settings(s);
      // ask the receiver for its long hold-off while this phase keeps offering
      if (squeeze) hold_off_asks++;
      sent = 0;
      while (sent < n) begin
         burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
         while (burst > 0 && sent < n) begin
            px = directed ? directed_pixel(sent) : random_pixel();
            drive_pixel(px);
            sent++;
            burst--;
         end
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      pause_sender(1);
   endtask

   // Receiver: alternate ready runs and stall runs of random length, with the
   // odd long stretch of no stalls; on request, hold off for a long count so
   // the pipeline backs up into req_bus.
   initial begin
      int   holds_served;
      int   hold_left;
      int   run_left;
      logic ready_level;
      holds_served  = 0;
      hold_left     = 0;
      run_left      = 0;
      ready_level   = 1'b0;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_asks != holds_served) begin
            holds_served = hold_off_asks;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               ready_level = ~ready_level;
               if (ready_level)
                  run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 20);
               else
                  run_left = $urandom_range(1, 7);
            end
            run_left--;
            rsp_bus.ready <= ready_level;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      cfg_type s;
      req_bus.valid            = 1'b0;
      req_bus.top_colour       = '0;
      req_bus.second_colour    = '0;
      req_bus.top_layer_bit    = '0;
      req_bus.second_layer_bit = '0;
      req_bus.top_class        = KIND_NORMAL;
      req_bus.sprite_alpha     = '0;
      req_bus.effects_enabled  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pixels under each effect, weights mostly at their extremes
      run_phase(make_setting({2'b11, 6'h3F, EFFECT_BLEND, 6'h3F}, 5'd16, 5'd16, 5'd0),
                DIRECTED_PIXELS, 1'b1, 1'b0);
      run_phase(make_setting({2'b00, 6'h3F, EFFECT_BRIGHTEN, 6'h3F}, 5'd31, 5'd0, 5'd31),
                DIRECTED_PIXELS, 1'b1, 1'b0);
      run_phase(make_setting({2'b10, 6'h3F, EFFECT_DARKEN, 6'h3F}, 5'd0, 5'd31, 5'd16),
                DIRECTED_PIXELS, 1'b1, 1'b0);
      run_phase(make_setting({2'b01, 6'h3F, EFFECT_NONE, 6'h3F}, 5'd5, 5'd11, 5'd0),
                DIRECTED_PIXELS, 1'b1, 1'b0);

      // random pixels: everything off, everything on at maximum, then mixed
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       s = make_setting(16'h0000, 5'd0, 5'd0, 5'd0);
            1:       s = make_setting(16'hFFFF, 5'd31, 5'd31, 5'd31);
            default: s = random_setting();
         endcase
         run_phase(s, PIXELS_PER_PHASE, 1'b0, p == SQUEEZE_PHASE);
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: give up well past the slowest run the stimulus can make.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
